/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C master byte engine: command codes, the
// decoded request that passes from the front to the back, the result record
// and the bus state machine states.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned QDEPTH = 2;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd5;

	typedef enum logic [1:0] {
		K_TICK,
		K_BEGIN,
		K_LOAD,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] device_address;
		logic       read_not_write;
		logic [7:0] byte_count;
		logic       send_stop;
		logic [7:0] tx_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       tx_request;
		logic       busy_res;
		logic       done_res;
		logic       nack_error;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'd0,
		ST_SA    = 5'd1,
		ST_SB    = 5'd2,
		ST_SC    = 5'd3,
		ST_SD    = 5'd4,
		ST_TP1   = 5'd5,
		ST_TP2   = 5'd6,
		ST_TSET  = 5'd7,
		ST_THIGH = 5'd8,
		ST_TLOW  = 5'd9,
		ST_AREL  = 5'd10,
		ST_AHIGH = 5'd11,
		ST_WTX   = 5'd12,
		ST_RLOW  = 5'd13,
		ST_RHIGH = 5'd14,
		ST_MSET  = 5'd15,
		ST_MHIGH = 5'd16,
		ST_PA    = 5'd17,
		ST_PB    = 5'd18,
		ST_PC    = 5'd19,
		ST_PD    = 5'd20
	} state_t;

endpackage

/* rtl/i2cm_front.sv */
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts requests, decodes the command code and holds decoded requests in
// a two-entry queue for the bus engine.
// ----------------------------------------------------------------------------
module i2cm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    cmd,
	input  logic [6:0]    device_address,
	input  logic          read_not_write,
	input  logic [7:0]    byte_count,
	input  logic          send_stop,
	input  logic [7:0]    tx_byte,
	input  logic          sda_in,
	output logic          item_valid,
	output i2cm_pkg::item_t item,
	input  logic          item_take
);
	import i2cm_pkg::*;

	item_t      fifo_q [QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	item_t      dec;
	logic       do_push, do_pop;

	always_comb begin
		dec.device_address = device_address;
		dec.read_not_write = read_not_write;
		dec.byte_count     = byte_count;
		dec.send_stop      = send_stop;
		dec.tx_byte        = tx_byte;
		dec.sda_in         = sda_in;
		unique case (cmd)
			CMD_TICK:  dec.kind = K_TICK;
			CMD_BEGIN: dec.kind = K_BEGIN;
			CMD_LOAD:  dec.kind = K_LOAD;
			default:   dec.kind = K_NOP;
		endcase
	end

	assign full       = (count_q == 2'(QDEPTH));
	assign item_valid = (count_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

/* rtl/i2cm_back.sv */
// ----------------------------------------------------------------------------
// i2cm_back
// Bus engine: while its result queue has room, carries out one decoded request
// per cycle on the SCL/SDA state machine, one result each to a 2-entry queue.
// ----------------------------------------------------------------------------
module i2cm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_data,
	input  logic            item_valid,
	input  i2cm_pkg::item_t item,
	output logic            item_take,
	output logic            res_empty,
	output i2cm_pkg::res_t  res,
	input  logic            res_pop
);
	import i2cm_pkg::*;

	logic [15:0] phase_ticks_q;

	state_t      st_q, st_d;
	logic [15:0] timer_q, timer_d;
	logic [3:0]  bc_q, bc_d;
	logic [7:0]  sh_q, sh_d;
	logic [7:0]  br_q, br_d;
	logic        dir_q, dir_d;
	logic        stp_q, stp_d;
	logic        nack_q, nack_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        oe_q, oe_d;

	logic        ev_done, ev_rx;
	logic [7:0]  ev_byte;
	logic [15:0] enter_val, timer_dec;
	logic [3:0]  bc_inc;
	logic [7:0]  sh_rx, br_dec;
	res_t        res_new;

	res_t        rq_q [QDEPTH];
	logic        rq_wr_q, rq_rd_q;
	logic [1:0]  rq_count_q;
	logic        do_pop;

	assign enter_val = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
	assign timer_dec = (timer_q != 16'd0) ? timer_q - 16'd1 : 16'd0;
	assign bc_inc    = bc_q + 4'd1;
	assign sh_rx     = {sh_q[6:0], item.sda_in};
	assign br_dec    = (br_q != 8'd0) ? br_q - 8'd1 : 8'd0;

	always_comb begin
		st_d    = st_q;
		timer_d = timer_q;
		bc_d    = bc_q;
		sh_d    = sh_q;
		br_d    = br_q;
		dir_d   = dir_q;
		stp_d   = stp_q;
		nack_d  = nack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		oe_d    = oe_q;
		ev_done = 1'b0;
		ev_rx   = 1'b0;
		ev_byte = 8'd0;
		case (item.kind)
			K_TICK: begin
				if (st_q != ST_IDLE && st_q != ST_WTX) begin
					timer_d = timer_dec;
					if (timer_dec == 16'd0) begin
						timer_d = enter_val;
						unique case (st_q)
							ST_SA: begin scl_d = 1'b1; st_d = ST_SB; end
							ST_SB: begin sda_d = 1'b0; st_d = ST_SC; end
							ST_SC: begin scl_d = 1'b0; st_d = ST_SD; end
							ST_SD: begin
								oe_d  = 1'b1;
								scl_d = 1'b0;
								st_d  = ST_TP1;
							end
							ST_TP1: st_d = ST_TP2;
							ST_TP2: begin
								bc_d  = 4'd0;
								sda_d = sh_q[7];
								st_d  = ST_TSET;
							end
							ST_TSET: begin
								sh_d  = {sh_q[6:0], 1'b0};
								scl_d = 1'b1;
								st_d  = ST_THIGH;
							end
							ST_THIGH: begin scl_d = 1'b0; st_d = ST_TLOW; end
							ST_TLOW: begin
								bc_d = bc_inc;
								if (bc_inc < 4'd8) begin
									sda_d = sh_q[7];
									st_d  = ST_TSET;
								end else begin
									sda_d = 1'b1;
									oe_d  = 1'b0;
									st_d  = ST_AREL;
								end
							end
							ST_AREL: begin scl_d = 1'b1; st_d = ST_AHIGH; end
							ST_AHIGH: begin
								if (item.sda_in) begin
									nack_d = 1'b1;
									if (stp_q) begin
										oe_d  = 1'b1;
										scl_d = 1'b0;
										st_d  = ST_PA;
									end else begin
										st_d    = ST_IDLE;
										timer_d = 16'd0;
										ev_done = 1'b1;
									end
								end else begin
									scl_d = 1'b0;
									if (dir_q) begin
										if (br_q == 8'd0) begin
											oe_d  = 1'b1;
											sda_d = 1'b1;
											st_d  = ST_MSET;
										end else begin
											sda_d = 1'b1;
											oe_d  = 1'b0;
											sh_d  = 8'd0;
											bc_d  = 4'd0;
											st_d  = ST_RLOW;
										end
									end else if (br_q == 8'd0) begin
										if (stp_q) begin
											oe_d = 1'b1;
											st_d = ST_PA;
										end else begin
											st_d    = ST_IDLE;
											timer_d = 16'd0;
											ev_done = 1'b1;
										end
									end else begin
										st_d    = ST_WTX;
										timer_d = 16'd0;
									end
								end
							end
							ST_RLOW: begin scl_d = 1'b1; st_d = ST_RHIGH; end
							ST_RHIGH: begin
								sh_d  = sh_rx;
								bc_d  = bc_inc;
								scl_d = 1'b0;
								if (bc_inc < 4'd8) begin
									st_d = ST_RLOW;
								end else begin
									ev_rx   = 1'b1;
									ev_byte = sh_rx;
									br_d    = br_dec;
									oe_d    = 1'b1;
									sda_d   = (br_dec == 8'd0);
									st_d    = ST_MSET;
								end
							end
							ST_MSET: begin scl_d = 1'b1; st_d = ST_MHIGH; end
							ST_MHIGH: begin
								scl_d = 1'b0;
								if (br_q != 8'd0) begin
									sda_d = 1'b1;
									oe_d  = 1'b0;
									sh_d  = 8'd0;
									bc_d  = 4'd0;
									st_d  = ST_RLOW;
								end else if (stp_q) begin
									oe_d = 1'b1;
									st_d = ST_PA;
								end else begin
									st_d    = ST_IDLE;
									timer_d = 16'd0;
									ev_done = 1'b1;
								end
							end
							ST_PA: begin sda_d = 1'b0; st_d = ST_PB; end
							ST_PB: begin scl_d = 1'b1; st_d = ST_PC; end
							ST_PC: begin sda_d = 1'b1; st_d = ST_PD; end
							ST_PD: begin
								st_d    = ST_IDLE;
								timer_d = 16'd0;
								ev_done = 1'b1;
							end
							default: begin
								st_d    = ST_IDLE;
								timer_d = 16'd0;
							end
						endcase
					end
				end
			end
			K_BEGIN: begin
				if (st_q == ST_IDLE) begin
					dir_d   = item.read_not_write;
					br_d    = item.byte_count;
					stp_d   = item.send_stop;
					sh_d    = {item.device_address, item.read_not_write};
					bc_d    = 4'd0;
					nack_d  = 1'b0;
					oe_d    = 1'b1;
					sda_d   = 1'b1;
					st_d    = ST_SA;
					timer_d = enter_val;
				end
			end
			K_LOAD: begin
				if (st_q == ST_WTX) begin
					sh_d    = item.tx_byte;
					br_d    = br_dec;
					oe_d    = 1'b1;
					scl_d   = 1'b0;
					st_d    = ST_TP1;
					timer_d = enter_val;
				end
			end
			default: ;
		endcase

		res_new.scl_level        = scl_d;
		res_new.sda_level        = sda_d;
		res_new.sda_drive_enable = oe_d;
		res_new.rx_byte          = ev_byte;
		res_new.rx_valid         = ev_rx;
		res_new.tx_request       = (st_d == ST_WTX);
		res_new.busy_res         = (st_d != ST_IDLE);
		res_new.done_res         = ev_done;
		res_new.nack_error       = ev_done && nack_d;
	end

	// take a request whenever the result queue has a free slot this cycle
	assign do_pop    = res_pop && (rq_count_q != 2'd0);
	assign item_take = item_valid && ((rq_count_q != 2'(QDEPTH)) || do_pop);
	assign res_empty = (rq_count_q == 2'd0);
	assign res       = rq_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (item_take) begin
			rq_q[rq_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			st_q          <= ST_IDLE;
			timer_q       <= 16'd0;
			bc_q          <= 4'd0;
			sh_q          <= 8'd0;
			br_q          <= 8'd0;
			dir_q         <= 1'b0;
			stp_q         <= 1'b0;
			nack_q        <= 1'b0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			oe_q          <= 1'b0;
			rq_wr_q       <= 1'b0;
			rq_rd_q       <= 1'b0;
			rq_count_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				phase_ticks_q <= cfg_data;
			end
			if (item_take) begin
				st_q    <= st_d;
				timer_q <= timer_d;
				bc_q    <= bc_d;
				sh_q    <= sh_d;
				br_q    <= br_d;
				dir_q   <= dir_d;
				stp_q   <= stp_d;
				nack_q  <= nack_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				oe_q    <= oe_d;
				rq_wr_q <= ~rq_wr_q;
			end
			if (do_pop) begin
				rq_rd_q <= ~rq_rd_q;
			end
			rq_count_q <= rq_count_q + 2'(item_take) - 2'(do_pop);
		end
	end

endmodule

/* rtl/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that turns a stream of tick, begin and write-byte requests into
// SCL/SDA pin levels, one result record per request.
// ----------------------------------------------------------------------------
// Every request yields exactly one result, in order. The block takes one
// request per clock and gives one result per clock while results are popped:
// the bus engine updates its whole state machine in one step per request, so
// that one step sets the rate. A request waits in the front queue until the
// engine takes it, and the engine writes its result straight into the result
// queue, whose head drives the result ports. Each side has a
// two-entry queue, so a stalled consumer fills the result queue first and
// then the request queue before full rises. phase_ticks (reset 5, zero taken
// as one) sets how many tick requests each SCL or SDA phase lasts; write it
// only while no request is in flight. A bus transaction runs: start, address
// byte with acknowledge, then either write bytes (tx_request asks for each
// via a write-byte request) or read bytes (acknowledged but for the last),
// and an optional stop. A missing acknowledge ends it with nack_error and at
// most one stop.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        phase_ticks_wr_en,
	input  logic [15:0] phase_ticks_wr_data,
	// request side
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [6:0]  device_address,
	input  logic        read_not_write,
	input  logic [7:0]  byte_count,
	input  logic        send_stop,
	input  logic [7:0]  tx_byte,
	input  logic        sda_in,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_drive_enable,
	output logic [7:0]  rx_byte,
	output logic        rx_valid,
	output logic        tx_request,
	output logic        busy_res,
	output logic        done_res,
	output logic        nack_error
);
	import i2cm_pkg::*;

	// decoded request handed from the front queue to the engine
	item_t item;
	logic  item_valid;
	logic  item_take;
	res_t  res;

	// front: decode the command and hold up to two requests
	i2cm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.cmd            (cmd),
		.device_address (device_address),
		.read_not_write (read_not_write),
		.byte_count     (byte_count),
		.send_stop      (send_stop),
		.tx_byte        (tx_byte),
		.sda_in         (sda_in),
		.item_valid     (item_valid),
		.item           (item),
		.item_take      (item_take)
	);

	// back: advance the bus state machine and queue the results
	i2cm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (phase_ticks_wr_en),
		.cfg_data   (phase_ticks_wr_data),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_empty  (empty),
		.res        (res),
		.res_pop    (pop)
	);

	// split the head result onto its ports
	assign scl_level        = res.scl_level;
	assign sda_level        = res.sda_level;
	assign sda_drive_enable = res.sda_drive_enable;
	assign rx_byte          = res.rx_byte;
	assign rx_valid         = res.rx_valid;
	assign tx_request       = res.tx_request;
	assign busy_res         = res.busy_res;
	assign done_res         = res.done_res;
	assign nack_error       = res.nack_error;

endmodule
